// ===== rtl/bsc_pkg.sv =====
// shared constants for the barometric sensor compensation pipeline
package bsc_pkg;

  // field widths
  localparam int RAW_P_W = 20;
  localparam int RAW_T_W = 20;
  localparam int RAW_H_W = 16;
  localparam int TEMP_W  = 15;
  localparam int PRESS_W = 25;
  localparam int HUM_W   = 17;

  // configuration port
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_TEMP_COEFFS  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PRESS_A      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PRESS_B      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PRESS_NINE   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_HUM_COEFFS   = 3'd4;

  // result limits
  localparam int TEMP_MIN   = -4000;
  localparam int TEMP_MAX   = 8500;
  localparam int PRESS_MAX  = 28160000;
  localparam int HUM_V_MAX  = 419430400;
  localparam int HUM_MAX    = 102400;
  localparam int S32_MAX    = 2147483647;
  localparam int S32_MIN    = -2147483647 - 1;

  // pressure quotient scale and saturation
  localparam int PRESS_SCALE = 3125;
  localparam int QUOT_W      = 36;
  localparam logic [QUOT_W-1:0] PQ_LIMIT = 36'h8_0000_0000;

  // pipeline shape
  localparam int FRONT_STAGES = 14;
  localparam int DIV_STEPS    = QUOT_W;
  localparam int BACK_STAGES  = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

endpackage

// ===== rtl/barometric_sensor_compensation.sv =====
// barometric sensor compensation: pipelined temperature, pressure and humidity datapath
// throughput: one reading per cycle while out_ready holds; stages advance independently, so bubbles close up
// the pressure quotient comes from a 36-stage restoring divider, one quotient bit a stage
// reset (rst, synchronous) clears all stage valid bits and the coefficient registers
module barometric_sensor_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsc_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [bsc_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bsc_pkg::RAW_P_W-1:0]        raw_pressure,
  input  logic [bsc_pkg::RAW_T_W-1:0]        raw_temperature,
  input  logic [bsc_pkg::RAW_H_W-1:0]        raw_humidity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bsc_pkg::TEMP_W-1:0]  temperature_centi,
  output logic [bsc_pkg::PRESS_W-1:0]        pressure_q8,
  output logic                               pressure_invalid,
  output logic [bsc_pkg::HUM_W-1:0]          humidity_q10
);
  import bsc_pkg::*;

  localparam int DIV_BASE = FRONT_STAGES - 1;
  localparam int P0 = FRONT_STAGES + DIV_STEPS;

  // coefficient registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [63:0] press_coeffs_b;
  logic [15:0] press_coeff_nine;
  logic [63:0] hum_coeffs;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
      hum_coeffs       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_COEFFS: temp_coeffs      <= cfg_data[47:0];
        REG_PRESS_A:     press_coeffs_a   <= cfg_data;
        REG_PRESS_B:     press_coeffs_b   <= cfg_data;
        REG_PRESS_NINE:  press_coeff_nine <= cfg_data[15:0];
        REG_HUM_COEFFS:  hum_coeffs       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0] h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0] h6;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = press_coeffs_a[15:0];
  assign p2 = $signed(press_coeffs_a[31:16]);
  assign p3 = $signed(press_coeffs_a[47:32]);
  assign p4 = $signed(press_coeffs_a[63:48]);
  assign p5 = $signed(press_coeffs_b[15:0]);
  assign p6 = $signed(press_coeffs_b[31:16]);
  assign p7 = $signed(press_coeffs_b[47:32]);
  assign p8 = $signed(press_coeffs_b[63:48]);
  assign p9 = $signed(press_coeff_nine);
  assign h1 = hum_coeffs[7:0];
  assign h2 = $signed(hum_coeffs[23:8]);
  assign h3 = hum_coeffs[31:24];
  assign h4 = $signed(hum_coeffs[43:32]);
  assign h5 = $signed(hum_coeffs[55:44]);
  assign h6 = $signed(hum_coeffs[63:56]);

  // stage valids and per-stage advance
  logic [NUM_STAGES-1:0] v, en, v_in;

  assign en[NUM_STAGES-1] = ~v[NUM_STAGES-1] | out_ready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign v_in = {v[NUM_STAGES-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) v[k] <= v_in[k];
      end
    end
  end

  // front stage registers
  logic [19:0] s0_rp, s0_rt, s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp;
  logic [15:0] s0_rh, s1_rh, s2_rh, s3_rh, s4_rh, s5_rh;
  logic signed [33:0] s1_ta_p, s1_d2;
  logic signed [22:0] s2_ta;
  logic signed [37:0] s2_tb_p;
  logic signed [23:0] s3_tf;
  logic signed [14:0] s4_temp, s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic signed [14:0] s11_temp, s12_temp;
  logic signed [24:0] s4_pa, s4_hv;
  logic signed [47:0] s5_pa2;
  logic signed [40:0] s5_pa_p5, s5_pa_p2, s6_pa_p5, s6_pa_p2;
  logic signed [36:0] s5_h5v;
  logic signed [32:0] s5_g1p;
  logic signed [33:0] s5_g2p;
  logic signed [63:0] s6_b_a, s6_x_a, s7_b;
  logic signed [38:0] s6_f1sum;
  logic signed [22:0] s6_g1;
  logic signed [23:0] s6_g2;
  logic signed [54:0] s7_x;
  logic signed [23:0] s7_f1, s8_f1, s9_f1, s10_f1;
  logic signed [46:0] s7_gg;
  logic signed [55:0] s8_qp1;
  logic [32:0] s8_rp1;
  logic signed [63:0] s8_num, s9_num;
  logic signed [35:0] s8_f2a;
  logic signed [39:0] s9_a;
  logic signed [51:0] s9_f2p;
  logic s10_inv, s10_neg, s11_inv, s11_neg, s12_inv, s12_neg;
  logic [38:0] s10_abs_a, s11_abs_a, s12_abs_a;
  logic [62:0] s10_abs_n;
  logic signed [37:0] s10_f2;
  logic [43:0] s11_d_lo;
  logic [42:0] s11_d_hi;
  logic signed [61:0] s11_fp;
  logic [74:0] s12_d;
  logic signed [31:0] s12_hv2;

  // divider chain, entry 0 is the last front stage
  logic [38:0]        dv_rem   [DIV_STEPS+1];
  logic [35:0]        dv_dq    [DIV_STEPS+1];
  logic [38:0]        dv_abs_a [DIV_STEPS+1];
  logic               dv_ovf   [DIV_STEPS+1];
  logic               dv_neg   [DIV_STEPS+1];
  logic               dv_inv   [DIV_STEPS+1];
  logic signed [14:0] dv_temp  [DIV_STEPS+1];
  logic signed [31:0] dv_hv2   [DIV_STEPS+1];
  logic signed [33:0] dv_s2    [DIV_STEPS+1];

  // combinational helpers
  logic signed [17:0] tx;
  logic signed [16:0] td;
  logic signed [26:0] t5, tt;
  logic signed [14:0] temp_next;
  logic [20:0] pm;
  logic signed [31:0] hv2_next;

  always_comb begin
    tx = $signed({1'b0, s0_rt[19:3]}) - $signed({1'b0, t1, 1'b0});
    td = $signed({1'b0, s0_rt[19:4]}) - $signed({1'b0, t1});
    t5 = 27'(s3_tf) * 27'sd5 + 27'sd128;
    tt = t5 >>> 8;
    if (tt < 27'(TEMP_MIN)) temp_next = 15'(TEMP_MIN);
    else if (tt > 27'(TEMP_MAX)) temp_next = 15'(TEMP_MAX);
    else temp_next = 15'(tt);
    pm = 21'd1048576 - {1'b0, s7_rp};
    if (s11_fp > 62'(S32_MAX)) hv2_next = 32'(S32_MAX);
    else if (s11_fp < 62'(S32_MIN)) hv2_next = 32'(S32_MIN);
    else hv2_next = 32'(s11_fp);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_rp <= raw_pressure;
      s0_rt <= raw_temperature;
      s0_rh <= raw_humidity;
    end
    // temperature
    if (en[1]) begin
      s1_ta_p <= tx * t2;
      s1_d2   <= td * td;
      s1_rp   <= s0_rp;
      s1_rh   <= s0_rh;
    end
    if (en[2]) begin
      s2_ta   <= 23'(s1_ta_p >>> 11);
      s2_tb_p <= $signed(s1_d2[33:12]) * t3;
      s2_rp   <= s1_rp;
      s2_rh   <= s1_rh;
    end
    if (en[3]) begin
      s3_tf <= 24'(s2_ta) + 24'(s2_tb_p >>> 14);
      s3_rp <= s2_rp;
      s3_rh <= s2_rh;
    end
    if (en[4]) begin
      s4_temp <= temp_next;
      s4_pa   <= 25'(s3_tf) - 25'sd128000;
      s4_hv   <= 25'(s3_tf) - 25'sd76800;
      s4_rp   <= s3_rp;
      s4_rh   <= s3_rh;
    end
    // pressure numerator and divisor terms and humidity factors
    if (en[5]) begin
      s5_pa2   <= s4_pa * s4_pa;
      s5_pa_p5 <= s4_pa * p5;
      s5_pa_p2 <= s4_pa * p2;
      s5_h5v   <= s4_hv * h5;
      s5_g1p   <= s4_hv * h6;
      s5_g2p   <= s4_hv * $signed({1'b0, h3});
      s5_temp  <= s4_temp;
      s5_rp    <= s4_rp;
      s5_rh    <= s4_rh;
    end
    if (en[6]) begin
      s6_b_a   <= s5_pa2 * p6;
      s6_x_a   <= s5_pa2 * p3;
      s6_pa_p5 <= s5_pa_p5;
      s6_pa_p2 <= s5_pa_p2;
      s6_f1sum <= $signed({9'd0, s5_rh, 14'd0}) - $signed({{7{h4[11]}}, h4, 20'd0})
                  - 39'(s5_h5v) + 39'sd16384;
      s6_g1    <= 23'(s5_g1p >>> 10);
      s6_g2    <= 24'((s5_g2p >>> 11) + 34'sd32768);
      s6_temp  <= s5_temp;
      s6_rp    <= s5_rp;
    end
    if (en[7]) begin
      s7_b    <= s6_b_a + (64'(s6_pa_p5) <<< 17) + (64'(p4) <<< 35);
      s7_x    <= 55'((s6_x_a >>> 8) + (64'(s6_pa_p2) <<< 12) + (64'sd1 <<< 47));
      s7_f1   <= 24'(s6_f1sum >>> 15);
      s7_gg   <= s6_g1 * s6_g2;
      s7_temp <= s6_temp;
      s7_rp   <= s6_rp;
    end
    if (en[8]) begin
      s8_qp1  <= (s7_x >>> 17) * $signed({1'b0, p1});
      s8_rp1  <= s7_x[16:0] * p1;
      s8_num  <= $signed({12'd0, pm, 31'd0}) - s7_b;
      s8_f2a  <= 36'((s7_gg >>> 10) + 47'sd2097152);
      s8_f1   <= s7_f1;
      s8_temp <= s7_temp;
    end
    if (en[9]) begin
      s9_a    <= 40'((s8_qp1 + 56'($signed({1'b0, s8_rp1[32:17]}))) >>> 16);
      s9_num  <= s8_num;
      s9_f2p  <= s8_f2a * h2;
      s9_f1   <= s8_f1;
      s9_temp <= s8_temp;
    end
    // sign and magnitude for the divider
    if (en[10]) begin
      s10_inv   <= (s9_a == '0);
      s10_neg   <= s9_a[39] ^ s9_num[63];
      s10_abs_a <= 39'(s9_a[39] ? -s9_a : s9_a);
      s10_abs_n <= 63'(s9_num[63] ? -s9_num : s9_num);
      s10_f2    <= 38'((s9_f2p + 52'sd8192) >>> 14);
      s10_f1    <= s9_f1;
      s10_temp  <= s9_temp;
    end
    // scaled dividend in two partial products
    if (en[11]) begin
      s11_d_lo  <= s10_abs_n[31:0] * 12'(PRESS_SCALE);
      s11_d_hi  <= s10_abs_n[62:32] * 12'(PRESS_SCALE);
      s11_fp    <= s10_f1 * s10_f2;
      s11_inv   <= s10_inv;
      s11_neg   <= s10_neg;
      s11_abs_a <= s10_abs_a;
      s11_temp  <= s10_temp;
    end
    if (en[12]) begin
      s12_d     <= 75'(s11_d_lo) + {s11_d_hi, 32'd0};
      s12_hv2   <= hv2_next;
      s12_inv   <= s11_inv;
      s12_neg   <= s11_neg;
      s12_abs_a <= s11_abs_a;
      s12_temp  <= s11_temp;
    end
    // quotient overflow check and divider load
    if (en[DIV_BASE]) begin
      dv_ovf[0]   <= s12_d[74:36] >= s12_abs_a;
      dv_rem[0]   <= s12_d[74:36];
      dv_dq[0]    <= s12_d[35:0];
      dv_abs_a[0] <= s12_abs_a;
      dv_neg[0]   <= s12_neg;
      dv_inv[0]   <= s12_inv;
      dv_temp[0]  <= s12_temp;
      dv_hv2[0]   <= s12_hv2;
      dv_s2[0]    <= (s12_hv2 >>> 15) * (s12_hv2 >>> 15);
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [39:0] trial;
    logic        fits;
    assign trial = {dv_rem[j-1], dv_dq[j-1][35]};
    assign fits  = trial >= {1'b0, dv_abs_a[j-1]};

    always_ff @(posedge clk) begin
      if (en[DIV_BASE + j]) begin
        dv_rem[j]   <= fits ? 39'(trial - {1'b0, dv_abs_a[j-1]}) : trial[38:0];
        dv_dq[j]    <= {dv_dq[j-1][34:0], fits};
        dv_abs_a[j] <= dv_abs_a[j-1];
        dv_ovf[j]   <= dv_ovf[j-1];
        dv_neg[j]   <= dv_neg[j-1];
        dv_inv[j]   <= dv_inv[j-1];
        dv_temp[j]  <= dv_temp[j-1];
        dv_hv2[j]   <= dv_hv2[j-1];
        dv_s2[j]    <= dv_s2[j-1];
      end
    end
  end

  // back stages
  logic signed [36:0] q0_p, q1_p, q2_p;
  logic signed [35:0] q0_s2h;
  logic signed [31:0] q0_hv2;
  logic q0_inv, q1_inv, q2_inv, q3_inv;
  logic signed [14:0] q0_temp, q1_temp, q2_temp, q3_temp;
  logic signed [47:0] q1_ps2;
  logic signed [52:0] q1_c2p;
  logic [16:0] q1_hum, q2_hum, q3_hum;
  logic signed [63:0] q2_c1p;
  logic signed [33:0] q2_c2;
  logic signed [39:0] q3_sum;
  logic signed [14:0] o_temp;
  logic [24:0] o_press;
  logic o_inv;
  logic [16:0] o_hum;

  logic [35:0] pmag;
  logic signed [32:0] hd;
  logic [16:0] hum_next;
  logic signed [31:0] pp;
  logic [24:0] press_next;

  always_comb begin
    // saturate the quotient magnitude at the pressure limit
    if (dv_ovf[DIV_STEPS] || dv_dq[DIV_STEPS] > PQ_LIMIT) pmag = PQ_LIMIT;
    else pmag = dv_dq[DIV_STEPS];
    hd = 33'(q0_hv2) - 33'(q0_s2h >>> 4);
    if (hd[32]) hum_next = '0;
    else if (hd > 33'(HUM_V_MAX)) hum_next = 17'(HUM_MAX);
    else hum_next = hd[28:12];
    pp = 32'(q3_sum >>> 8) + (32'(p7) <<< 4);
    if (q3_inv || pp[31]) press_next = '0;
    else if (pp > 32'(PRESS_MAX)) press_next = 25'(PRESS_MAX);
    else press_next = pp[24:0];
  end

  always_ff @(posedge clk) begin
    if (en[P0]) begin
      q0_p    <= dv_neg[DIV_STEPS] ? 37'sd0 - $signed({1'b0, pmag}) : $signed({1'b0, pmag});
      q0_s2h  <= (dv_s2[DIV_STEPS] >>> 7) * $signed({1'b0, h1});
      q0_hv2  <= dv_hv2[DIV_STEPS];
      q0_inv  <= dv_inv[DIV_STEPS];
      q0_temp <= dv_temp[DIV_STEPS];
    end
    if (en[P0+1]) begin
      q1_p    <= q0_p;
      q1_ps2  <= (q0_p >>> 13) * (q0_p >>> 13);
      q1_c2p  <= q0_p * p8;
      q1_hum  <= hum_next;
      q1_inv  <= q0_inv;
      q1_temp <= q0_temp;
    end
    if (en[P0+2]) begin
      q2_p    <= q1_p;
      q2_c1p  <= q1_ps2 * p9;
      q2_c2   <= 34'(q1_c2p >>> 19);
      q2_hum  <= q1_hum;
      q2_inv  <= q1_inv;
      q2_temp <= q1_temp;
    end
    if (en[P0+3]) begin
      q3_sum  <= 40'(q2_p) + 40'(q2_c1p >>> 25) + 40'(q2_c2);
      q3_hum  <= q2_hum;
      q3_inv  <= q2_inv;
      q3_temp <= q2_temp;
    end
    // output register
    if (en[P0+4]) begin
      o_press <= press_next;
      o_inv   <= q3_inv;
      o_hum   <= q3_hum;
      o_temp  <= q3_temp;
    end
  end

  assign out_valid         = v[NUM_STAGES-1];
  assign temperature_centi = o_temp;
  assign pressure_q8       = o_press;
  assign pressure_invalid  = o_inv;
  assign humidity_q10      = o_hum;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_invalid |-> pressure_q8 == '0)
    else $error("invalid pressure result is not zero");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready)
    else $error("input blocked while the pipeline has a bubble");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_centi >= 15'(TEMP_MIN) && temperature_centi <= 15'(TEMP_MAX)
                  && humidity_q10 <= 17'(HUM_MAX))
    else $error("result outside its range");

  a_transfer_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted transfer did not enter the pipeline");
`endif

endmodule

// ===== sim/bsc_checker.sv =====
// checker: predicts compensated readings and compares them with the output transfers
`timescale 1ns / 100ps
module bsc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsc_pkg::CFG_AW-1:0]        cfg_index,
  input  logic [bsc_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [bsc_pkg::RAW_P_W-1:0]       raw_pressure,
  input  logic [bsc_pkg::RAW_T_W-1:0]       raw_temperature,
  input  logic [bsc_pkg::RAW_H_W-1:0]       raw_humidity,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [bsc_pkg::TEMP_W-1:0] temperature_centi,
  input  logic [bsc_pkg::PRESS_W-1:0]       pressure_q8,
  input  logic                              pressure_invalid,
  input  logic [bsc_pkg::HUM_W-1:0]         humidity_q10,
  output int                                mismatches,
  output int                                pending,
  output int                                readings_done,
  output int                                invalid_seen
);
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     inval;
    logic [HUM_W-1:0]         hum;
  } reading_t;

  logic [47:0] temp_k;
  logic [63:0] press_ka, press_kb, hum_k;
  logic [15:0] press_k9;
  reading_t    expected_q[$];

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic reading_t compensate(longint rp, longint rt, longint rh);
    reading_t r;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, b, d, tf, x, q, rem, num, q1, r1, p, c1, c2, v, f1, f2, g1, g2, s;
    t1 = longint'(temp_k[15:0]);
    t2 = longint'($signed(temp_k[31:16]));
    t3 = longint'($signed(temp_k[47:32]));
    p1 = longint'(press_ka[15:0]);
    p2 = longint'($signed(press_ka[31:16]));
    p3 = longint'($signed(press_ka[47:32]));
    p4 = longint'($signed(press_ka[63:48]));
    p5 = longint'($signed(press_kb[15:0]));
    p6 = longint'($signed(press_kb[31:16]));
    p7 = longint'($signed(press_kb[47:32]));
    p8 = longint'($signed(press_kb[63:48]));
    p9 = longint'($signed(press_k9));
    h1 = longint'(hum_k[7:0]);
    h2 = longint'($signed(hum_k[23:8]));
    h3 = longint'(hum_k[31:24]);
    h4 = longint'($signed(hum_k[43:32]));
    h5 = longint'($signed(hum_k[55:44]));
    h6 = longint'($signed(hum_k[63:56]));

    // fine temperature
    a  = (((rt >>> 3) - t1 * 2) * t2) >>> 11;
    d  = (rt >>> 4) - t1;
    b  = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b;
    r.temp = TEMP_W'(clip((tf * 5 + 128) >>> 8, longint'(TEMP_MIN), longint'(TEMP_MAX)));

    // pressure
    a = tf - 128000;
    b = a * a * p6;
    b += a * p5 * 131072;
    b += p4 * (longint'(1) << 35);
    x   = ((a * a * p3) >>> 8) + a * p2 * 4096 + (longint'(1) << 47);
    q   = x >>> 17;
    rem = x & longint'(131071);
    a   = (q * p1 + ((rem * p1) >>> 17)) >>> 16;
    r.inval = (a == 0);
    if (a == 0) begin
      r.press = '0;
    end else begin
      num = (1048576 - rp) * (longint'(1) << 31) - b;
      q1  = num / a;
      r1  = num % a;
      if (q1 > (longint'(1) << 35)) p = longint'(1) << 35;
      else if (q1 < -(longint'(1) << 35)) p = -(longint'(1) << 35);
      else p = clip(3125 * q1 + (3125 * r1) / a, -(longint'(1) << 35), longint'(1) << 35);
      c1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      c2 = (p8 * p) >>> 19;
      p  = ((p + c1 + c2) >>> 8) + p7 * 16;
      r.press = PRESS_W'(clip(p, longint'(0), longint'(PRESS_MAX)));
    end

    // humidity
    v  = tf - 76800;
    f1 = (rh * 16384 - h4 * 1048576 - h5 * v + 16384) >>> 15;
    g1 = (v * h6) >>> 10;
    g2 = ((v * h3) >>> 11) + 32768;
    f2 = ((g1 * g2) >>> 10) + 2097152;
    f2 = (f2 * h2 + 8192) >>> 14;
    v  = clip(f1 * f2, longint'(S32_MIN), longint'(S32_MAX));
    s  = v >>> 15;
    s  = (((s * s) >>> 7) * h1) >>> 4;
    v  = clip(v - s, longint'(0), longint'(HUM_V_MAX));
    r.hum = HUM_W'(v >>> 12);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      temp_k   <= '0;
      press_ka <= '0;
      press_kb <= '0;
      press_k9 <= '0;
      hum_k    <= '0;
      expected_q.delete();
      mismatches    <= 0;
      pending       <= 0;
      readings_done <= 0;
      invalid_seen  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_COEFFS: temp_k   <= cfg_data[47:0];
          REG_PRESS_A:     press_ka <= cfg_data;
          REG_PRESS_B:     press_kb <= cfg_data;
          REG_PRESS_NINE:  press_k9 <= cfg_data[15:0];
          REG_HUM_COEFFS:  hum_k    <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(compensate(longint'(raw_pressure), longint'(raw_temperature),
                                        longint'(raw_humidity)));
      if (out_valid && out_ready) begin
        readings_done <= readings_done + 1;
        if (pressure_invalid) invalid_seen <= invalid_seen + 1;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.temp !== temperature_centi || want.press !== pressure_q8 ||
              want.inval !== pressure_invalid || want.hum !== humidity_q10) begin
            if (mismatches < 10)
              $display("mismatch: exp t=%0d p=%0d inv=%0b h=%0d  got t=%0d p=%0d inv=%0b h=%0d",
                       want.temp, want.press, want.inval, want.hum, temperature_centi,
                       pressure_q8, pressure_invalid, humidity_q10);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

// ===== sim/tb_top.sv =====
// testbench top: stimulus, flow control and verdict for the compensation pipeline
`timescale 1ns / 100ps
module tb_top;
  import bsc_pkg::*;

  logic                clk, rst;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;
  logic                in_valid, in_ready, out_valid, out_ready;
  logic [RAW_P_W-1:0]  raw_pressure;
  logic [RAW_T_W-1:0]  raw_temperature;
  logic [RAW_H_W-1:0]  raw_humidity;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [PRESS_W-1:0]  pressure_q8;
  logic                pressure_invalid;
  logic [HUM_W-1:0]    humidity_q10;
  int                  mismatches, pending, readings_done, invalid_seen;
  int                  idle_cycles;
  int                  readings_sent;
  bit                  quick;
  bit                  hold_req;

  barometric_sensor_compensation u_dut (.*);

  bsc_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // typical factory calibration
  localparam logic [47:0] TEMP_TYP = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] PA_TYP   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] PB_TYP   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] HUM_TYP  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // call just after a rising edge; withdraws the offer before the next edge
  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic load_coeffs(input logic [47:0] tk, input logic [63:0] pa, input logic [63:0] pb,
                             input logic [15:0] p9, input logic [63:0] hk);
    drop_valid();
    wait (pending == 0);
    repeat (60) @(posedge clk);
    write_reg(REG_TEMP_COEFFS, {16'd0, tk});
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_NINE, {48'd0, p9});
    write_reg(REG_HUM_COEFFS, hk);
  endtask

  // call just after a rising edge; returns just after the transfer edge
  task automatic send_reading(input logic [19:0] p, input logic [19:0] t, input logic [15:0] h);
    int gap;
    bit rdy;
    gap = quick ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= p;
    raw_temperature <= t;
    raw_humidity    <= h;
    do begin
      #1 rdy = in_ready;
      @(posedge clk);
      if (!rdy) @(negedge clk);
    end while (!rdy);
    readings_sent++;
  endtask

  task automatic send_random(input int n, input int typical_pct);
    logic [19:0] p, t;
    logic [15:0] h;
    repeat (n) begin
      if ($urandom_range(0, 99) < typical_pct) begin
        p = 20'(20'd415148 + $urandom_range(0, 200000) - 100000);
        t = 20'(20'd519888 + $urandom_range(0, 200000) - 100000);
        h = 16'(16'd30000 + $urandom_range(0, 30000) - 15000);
      end else begin
        p = 20'($urandom);
        t = 20'($urandom);
        h = 16'($urandom);
      end
      send_reading(p, t, h);
    end
  endtask

  task automatic send_edges();
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'd0, 20'hFFFFF, 16'd0);
    send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
    send_reading(20'd415148, 20'd519888, 16'd30000);
    send_reading(20'hAAAAA, 20'h55555, 16'h5555);
    send_reading(20'h55555, 20'hAAAAA, 16'hAAAA);
  endtask

  // result side: random stalls, quiet stretches, and a long hold-off on request
  initial begin
    int  stall;
    bit  v;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = quick ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do begin
        #1 v = out_valid;
        @(posedge clk);
        @(negedge clk);
      end while (!v);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("watchdog expired, %0d results still outstanding", pending);
      $display("[barometric_sensor_compensation] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    raw_humidity = '0;
    quick = 1'b0;
    hold_req = 1'b0;
    readings_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: zero pressure divisor
    send_edges();

    // typical calibration, directed then random
    load_coeffs(TEMP_TYP, PA_TYP, PB_TYP, 16'd6000, HUM_TYP);
    send_edges();
    send_reading(20'd415148, 20'd519888, 16'd0);
    send_reading(20'd415148, 20'd519888, 16'hFFFF);
    hold_req = 1'b1;
    send_random(120, 85);
    drop_valid();
    wait (pending == 0);
    quick = 1'b1;
    send_random(80, 85);
    quick = 1'b0;
    send_random(80, 50);

    // tiny divisor drives the quotient into saturation
    load_coeffs(TEMP_TYP, {PA_TYP[63:16], 16'd1}, PB_TYP, 16'h7FFF,
                {8'hFF, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 8'hFF});
    send_edges();
    send_random(60, 50);

    // extreme coefficients
    load_coeffs({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000,
                {8'h80, 12'h7FF, 12'h800, 8'h00, 16'h8000, 8'h00});
    send_edges();
    send_random(60, 30);
    load_coeffs('1, '1, '1, '1, '1);
    send_random(40, 30);

    // random calibrations
    repeat (4) begin
      load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom), {$urandom, $urandom});
      send_random(40, 40);
    end

    // back to typical, quiet stretch
    load_coeffs(TEMP_TYP, PA_TYP, PB_TYP, 16'd6000, HUM_TYP);
    quick = 1'b1;
    send_random(60, 80);
    quick = 1'b0;
    send_random(40, 80);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("%0d readings sent, %0d results checked, %0d flagged invalid pressure",
             readings_sent, readings_done, invalid_seen);
    $display("calibrations: reset, typical, saturating, extreme, all ones, random");
    if (mismatches == 0 && pending == 0)
      $display("[barometric_sensor_compensation] OK");
    else
      $display("[barometric_sensor_compensation] ERROR");
    $finish;
  end
endmodule

// ===== barometric_sensor_compensation.f =====
rtl/bsc_pkg.sv
rtl/barometric_sensor_compensation.sv
sim/bsc_checker.sv
sim/tb_top.sv
